// ===== hw/rtl/etp_pkg.sv =====
// ----------------------------------------------------------------------------
// etp_pkg
// Types, microcode table and control structs for the totient engine.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

    // dividend select
    typedef enum logic [0:0] {
        NUM_R,
        NUM_PHI
    } t_num;

    // divisor select
    typedef enum logic [0:0] {
        DEN_D,
        DEN_R
    } t_den;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_D_GT_Q,
        C_REM_NZ,
        C_REM_Z,
        C_R_LE1
    } t_cond;

    localparam int UPC_BITS = 4;
    typedef logic [UPC_BITS-1:0] t_upc;

    // program step addresses
    localparam t_upc UPC_TEST     = 4'd0;
    localparam t_upc UPC_BOUND    = 4'd1;
    localparam t_upc UPC_DIVCHK   = 4'd2;
    localparam t_upc UPC_PHI_D    = 4'd3;
    localparam t_upc UPC_STRIP    = 4'd4;
    localparam t_upc UPC_STRIP_J  = 4'd5;
    localparam t_upc UPC_NEXT     = 4'd6;
    localparam t_upc UPC_FINAL    = 4'd7;
    localparam t_upc UPC_PHI_R    = 4'd8;
    localparam t_upc UPC_DONE     = 4'd9;

    typedef struct packed {
        logic  div_go;
        t_num  num_sel;
        t_den  den_sel;
        logic  phi_sub;
        t_cond cond;
        logic  r_take_q;
        logic  d_step;
        logic  done;
        t_upc  target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        t_num num_sel;
        t_den den_sel;
        logic phi_sub;
        logic r_take_q;
        logic d_step;
        logic done;
    } t_ctl;

    // datapath -> sequencer
    typedef struct packed {
        logic div_done;
        logic d_gt_q;
        logic rem_nz;
        logic r_le1;
    } t_stat;

    function automatic t_uword etp_urom(input t_upc pc);
        t_uword w;
        begin
            w = '0;
            case (pc)
                UPC_TEST: begin
                    w.div_go  = 1'b1;
                    w.num_sel = NUM_R;
                    w.den_sel = DEN_D;
                end
                UPC_BOUND: begin
                    w.cond   = C_D_GT_Q;
                    w.target = UPC_FINAL;
                end
                UPC_DIVCHK: begin
                    w.cond   = C_REM_NZ;
                    w.target = UPC_NEXT;
                end
                UPC_PHI_D: begin
                    w.div_go  = 1'b1;
                    w.num_sel = NUM_PHI;
                    w.den_sel = DEN_D;
                    w.phi_sub = 1'b1;
                end
                UPC_STRIP: begin
                    w.div_go  = 1'b1;
                    w.num_sel = NUM_R;
                    w.den_sel = DEN_D;
                end
                UPC_STRIP_J: begin
                    w.cond     = C_REM_Z;
                    w.r_take_q = 1'b1;
                    w.target   = UPC_STRIP;
                end
                UPC_NEXT: begin
                    w.d_step = 1'b1;
                    w.cond   = C_ALWAYS;
                    w.target = UPC_TEST;
                end
                UPC_FINAL: begin
                    w.cond   = C_R_LE1;
                    w.target = UPC_DONE;
                end
                UPC_PHI_R: begin
                    w.div_go  = 1'b1;
                    w.num_sel = NUM_PHI;
                    w.den_sel = DEN_R;
                    w.phi_sub = 1'b1;
                end
                UPC_DONE: begin
                    w.done = 1'b1;
                end
                default: begin
                    w.done = 1'b1;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etp_divider.sv =====
// ----------------------------------------------------------------------------
// etp_divider
// Restoring divider, one quotient bit per cycle; results hold until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_divider #(
    parameter int unsigned WIDTH = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_num,
    input  wire logic [WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_quo,
    output logic [WIDTH-1:0]      o_rem
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH+1:0] diff;
    logic             qbit;

    always_comb begin
        rem_sh = {r_rem, r_quo[WIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        qbit   = ~diff[WIDTH+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the quotient register as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[WIDTH-2:0], qbit};
            r_rem <= qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/etp_sequencer.sv =====
// ----------------------------------------------------------------------------
// etp_sequencer
// Step counter over the microcode table, with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_sequencer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire etp_pkg::t_stat i_stat,
    output etp_pkg::t_ctl      o_ctl,
    output logic               o_busy
);

    import etp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;
    logic   taken;

    assign uw = etp_urom(r_pc);

    always_comb begin
        case (uw.cond)
            C_NEVER:  taken = 1'b0;
            C_ALWAYS: taken = 1'b1;
            C_D_GT_Q: taken = i_stat.d_gt_q;
            C_REM_NZ: taken = i_stat.rem_nz;
            C_REM_Z:  taken = ~i_stat.rem_nz;
            C_R_LE1:  taken = i_stat.r_le1;
            default:  taken = 1'b0;
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_pc            = r_pc;
        o_ctl           = '0;
        o_ctl.num_sel   = uw.num_sel;
        o_ctl.den_sel   = uw.den_sel;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_ctl.load = 1'b1;
                    n_pc       = UPC_TEST;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (uw.div_go) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = S_WAIT;
                end else if (uw.done) begin
                    o_ctl.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_ctl.r_take_q = uw.r_take_q & taken;
                    o_ctl.d_step   = uw.d_step;
                    n_pc           = taken ? uw.target : r_pc + t_upc'(1);
                end
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    o_ctl.phi_sub = uw.phi_sub;
                    n_pc          = r_pc + t_upc'(1);
                    n_state       = S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= UPC_TEST;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/euler_totient_trial_division.sv =====
// ----------------------------------------------------------------------------
// euler_totient_trial_division
// Euler totient of one value by trial division, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Operation: every division runs in the shared divider; the trial divisor sweep
//   takes up to ~2^19 divisors for a 40-bit prime.
// Throughput: one item at a time; busy stays high until the result strobe.
// Result: o_valid pulses one cycle with o_totient; the receiver cannot stall.
// Reset: synchronous active low; returns to idle, no result pending.
`default_nettype none

module euler_totient_trial_division #(
    parameter int unsigned VALUE_BITS = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       busy,
    output logic                       o_valid,
    output logic [VALUE_BITS-1:0]      o_totient
);

    import etp_pkg::*;

    // trial divisor never exceeds sqrt of the value plus one odd step
    localparam int unsigned DB = (VALUE_BITS + 1) / 2 + 2;

    t_ctl  ctl;
    t_stat stat;

    logic [VALUE_BITS-1:0] r_remaining;
    logic [VALUE_BITS-1:0] r_phi;
    logic [DB-1:0]         r_d;
    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_totient;

    logic [VALUE_BITS-1:0] d_ext;
    logic [VALUE_BITS-1:0] div_num;
    logic [VALUE_BITS-1:0] div_den;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;

    assign d_ext   = {{(VALUE_BITS - DB){1'b0}}, r_d};
    assign div_num = (ctl.num_sel == NUM_PHI) ? r_phi : r_remaining;
    assign div_den = (ctl.den_sel == DEN_R) ? r_remaining : d_ext;

    etp_divider #(
        .WIDTH (VALUE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        stat.div_done = div_done;
        stat.d_gt_q   = (d_ext > div_quo);
        stat.rem_nz   = (div_rem != '0);
        stat.r_le1    = (r_remaining <= VALUE_BITS'(1));
    end

    etp_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_phi       <= '0;
            r_d         <= DB'(2);
            r_totient   <= '0;
        end else begin
            if (ctl.load) begin
                r_remaining <= i_value;
                r_phi       <= i_value;
                r_d         <= DB'(2);
            end else begin
                if (ctl.phi_sub) begin
                    r_phi <= r_phi - div_quo;
                end
                if (ctl.r_take_q) begin
                    r_remaining <= div_quo;
                end
                if (ctl.d_step) begin
                    r_d <= (r_d == DB'(2)) ? DB'(3) : r_d + DB'(2);
                end
            end
            if (ctl.done) begin
                r_totient <= r_phi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl.done;
        end
    end

    assign o_valid   = r_valid;
    assign o_totient = r_totient;

endmodule

`default_nettype wire

// ===== hw/rtl/etp_checker.sv =====
// ----------------------------------------------------------------------------
// etp_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only follows a busy period and ends it
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding busy period");

    // busy only drops with a result
    a_fall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // one strobe per item
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

endmodule

bind euler_totient_trial_division etp_checker u_etp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire

// ===== tb/totient_checker.sv =====
// ----------------------------------------------------------------------------
// totient_checker
// Watches the totient engine's command and result ports, predicts phi(n)
// for every accepted value and compares each result strobe in order.
// ----------------------------------------------------------------------------
module totient_checker #(
    parameter int unsigned VALUE_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  o_valid,
    input  logic [VALUE_BITS-1:0] o_totient,
    output int                    errors,
    output int                    outstanding,
    output int                    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] totient;
    } t_owed;

    t_owed owed[$];
    int    err_count = 0;
    int    ok_count  = 0;
    int    owed_count = 0;

    assign errors      = err_count;
    assign outstanding = owed_count;
    assign checked     = ok_count;

    // phi(n) by trial division: 2, then odd divisors while d*d <= remainder
    function automatic logic [VALUE_BITS-1:0] totient_of(input logic [VALUE_BITS-1:0] n);
        longint unsigned rem;
        longint unsigned phi;
        longint unsigned d;
        if (n == '0) begin
            return '0;
        end
        rem = n;
        phi = n;
        for (d = 2; d <= rem / d; d = (d == 2) ? 3 : d + 2) begin
            if (rem % d == 0) begin
                phi -= phi / d;
                while (rem % d == 0)
                    rem /= d;
            end
        end
        // leftover above 1 is one last prime factor
        if (rem > 1)
            phi -= phi / rem;
        return phi[VALUE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_owed head;
        if (i_rst_n) begin
            // a strobe belongs to an earlier item, so retire before taking a new one
            if (o_valid) begin
                if (owed.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected totient: expected none, actual %0d",
                             $time, o_totient);
                end else begin
                    head = owed.pop_front();
                    ok_count++;
                    if (o_totient !== head.totient) begin
                        err_count++;
                        $display("%0t: totient of %0d: expected %0d, actual %0d",
                                 $time, head.value, head.totient, o_totient);
                    end
                end
            end
            if (start && !busy)
                owed.insert(owed.size(),
                            t_owed'{value: i_value, totient: totient_of(i_value)});
            owed_count = owed.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives values into the totient engine: directed edge cases first, then
// random smooth composites and small values, with random start gaps.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VB = 40;
    localparam int N_RANDOM = 76;
    localparam int N_DIRECTED = 24;

    // zero shows up twice to check that it leaves no state behind
    localparam logic [VB-1:0] DIRECTED[N_DIRECTED] = '{
        40'd0, 40'd1, 40'd2, 40'd3, 40'd4, 40'd5, 40'd6, 40'd7, 40'd8, 40'd9,
        40'd12, 40'd30, 40'd97, 40'd1024, 40'd60491, 40'd1042441, 40'd16777213,
        40'd200560490130, 40'd847288609443, 40'h80_0000_0000, 40'h55_5555_5555,
        40'hAA_AAAA_AAAA, 40'd0, 40'hFF_FFFF_FFFF
    };
    localparam int unsigned SMALL_PRIMES[18] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [VB-1:0] i_value = '0;
    logic          busy;
    logic          o_valid;
    logic [VB-1:0] o_totient;

    int errors;
    int outstanding;
    int checked;
    int sent = 0;

    euler_totient_trial_division #(.VALUE_BITS(VB)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_value   (i_value),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_totient (o_totient)
    );

    totient_checker #(.VALUE_BITS(VB)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_totient   (o_totient),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hold start high until the item is taken; drop it now and then unless steady
    task automatic feed_value(input logic [VB-1:0] v, input bit steady);
        bit taken;
        bit hold;
        taken = 1'b0;
        i_value <= v;
        while (!taken) begin
            hold = !steady && ($urandom_range(0, 99) < 7);
            start <= !hold;
            @(posedge i_clk);
            taken = !hold && !busy;
        end
        sent++;
    endtask

    initial begin
        longint unsigned acc;
        longint unsigned cap;
        int unsigned p;
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++)
            feed_value(DIRECTED[k], 1'b0);

        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                acc = 0;
            end else if (pick < 15) begin
                acc = $urandom_range(1, 65535);
            end else begin
                // smooth part up to a random width, times a cofactor below 2^16,
                // so the divisor sweep stays short
                cap = (64'd1 << $urandom_range(1, VB)) - 1;
                acc = $urandom_range(0, 1) ? longint'($urandom_range(1, 65535)) : 1;
                for (int j = 0; j < 48; j++) begin
                    p = SMALL_PRIMES[$urandom_range(0, 17)];
                    if (acc * p <= cap)
                        acc *= p;
                end
            end
            feed_value(acc[VB-1:0], k >= 35 && k < 65);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d values (%0d directed edge cases, the rest random smooth",
                 sent, N_DIRECTED);
        $display("composites and small values); %0d totients compared.", checked);
        if (errors == 0 && outstanding == 0) begin
            $display("PASS euler_totient_trial_division");
        end else begin
            $display("FAIL euler_totient_trial_division");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL euler_totient_trial_division");
        $finish;
    end

endmodule
